>>> rtl/assert_macros.svh
// assertion helpers used by mono_framebuffer_text_draw
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is high
`define MFB_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("mfb assertion failed");

// clocked property, checked during reset as well
`define MFB_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("mfb assertion failed");

`endif

>>> rtl/mfb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_pkg
// Shared constants, codes and types of the monochrome framebuffer text block.
// ----------------------------------------------------------------------------
package mfb_pkg;

   localparam int DISPLAY_WIDTH  = 128;
   localparam int DISPLAY_HEIGHT = 64;
   localparam int GLYPH_WORDS    = 2048;

   localparam int PAGE_COUNT  = (DISPLAY_HEIGHT + 7) / 8;
   localparam int FRAME_BYTES = PAGE_COUNT * DISPLAY_WIDTH;
   localparam int FRAME_AW    = $clog2(FRAME_BYTES);
   localparam int GLYPH_AW    = $clog2(GLYPH_WORDS);
   // glyph address before the modulo: code index up to 95 times height up to 31 rows
   localparam int GADDR_W     = (GLYPH_AW + 1 > 12) ? GLYPH_AW + 1 : 12;

   // pixel coordinates one bit wider than the panel, to hold origin plus glyph offset
   localparam int X_W = 8;
   localparam int Y_W = 7;

   localparam int FIRST_CODE = 32;

   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_FONT_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FONT_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INVERT      = 2'd2;

   localparam logic [4:0] FONT_WIDTH_RST  = 5'd7;
   localparam logic [4:0] FONT_HEIGHT_RST = 5'd10;

   typedef enum logic [2:0] {
      ACT_FILL   = 3'd0,
      ACT_PIXEL  = 3'd1,
      ACT_CURSOR = 3'd2,
      ACT_CHAR   = 3'd3,
      ACT_FONT   = 3'd4,
      ACT_READ   = 3'd5
   } action_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_REDUCE,
      ST_GROW,
      ST_PIX_RD,
      ST_PIX_WR,
      ST_READ,
      ST_RDCAP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [X_W-1:0] x;
      logic [Y_W-1:0] y;
      logic           white;
   } pix_req_type;

endpackage

>>> rtl/mfb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module mfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/mfb_pixel_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfb_pixel_unit
// Maps a pixel to its page byte and merges the pixel into that byte.
// ----------------------------------------------------------------------------
module mfb_pixel_unit (
   input  mfb_pkg::pix_req_type          pix,
   input  logic [7:0]                    old_byte,
   output logic [mfb_pkg::FRAME_AW-1:0]  byte_idx,
   output logic [7:0]                    new_byte
);

   logic [7:0] mask;

   always_comb begin
      mask     = 8'd1 << pix.y[2:0];
      new_byte = pix.white ? (old_byte | mask) : (old_byte & ~mask);
      // page = row / 8, byte = page * width + column
      byte_idx = mfb_pkg::FRAME_AW'(32'(pix.x)
                 + 32'(pix.y[mfb_pkg::Y_W-1:3]) * mfb_pkg::DISPLAY_WIDTH);
   end

endmodule

>>> rtl/mono_framebuffer_text_draw.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mono_framebuffer_text_draw
// Page-organised monochrome framebuffer with cursor, glyph store and text.
// ----------------------------------------------------------------------------
//  channel   | ports                    | contents
//  request   | req_tvalid/tready/tdata  | action in tuser, operands in tdata
//  response  | rsp_tvalid/tready/tdata  | read data and reject status
//  csr       | csr_we/index/wdata       | font width, font height, invert
//
//  work per item: a character first reduces its glyph address modulo the
//  store, then reads one glyph row per font row and draws its pixels; a
//  zero font size draws nothing. a fill writes every frame byte, and
//  every pixel is a read-modify-write through the frame memory ports.
//  after reset a clearing pass writes all FRAME_BYTES (1024) bytes with
//  req_tready low; csr writes are taken meanwhile.
//  one item at a time; a finished response waits in the output register
//  while the next request is already taken.
module mono_framebuffer_text_draw (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // pos_x[6:0], pos_y[12:7], color[13], char_code[20:14],
   // font_address[31:21], font_word[47:32], byte_address[57:48]
   input  logic [mfb_pkg::REQ_DATA_W-1:0]      req_tdata,
   // action[2:0]
   input  logic [mfb_pkg::REQ_USER_W-1:0]      req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // read_data[7:0], status[8]
   output logic [mfb_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                csr_we,
   input  logic [mfb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mfb_pkg::CSR_DATA_W-1:0]      csr_wdata
);

`include "assert_macros.svh"

   // request fields
   logic [6:0]  pos_x;
   logic [5:0]  pos_y;
   logic        color;
   logic [6:0]  char_code;
   logic [10:0] font_address;
   logic [15:0] font_word;
   logic [9:0]  byte_address;

   assign pos_x        = req_tdata[6:0];
   assign pos_y        = req_tdata[12:7];
   assign color        = req_tdata[13];
   assign char_code    = req_tdata[20:14];
   assign font_address = req_tdata[31:21];
   assign font_word    = req_tdata[47:32];
   assign byte_address = req_tdata[57:48];

   mfb_pkg::state_type state_ff, state_in;

   logic [4:0] fw_ff, fh_ff;
   logic       inv_ff;
   logic [6:0] ccol_ff, ccol_in;
   logic [5:0] crow_ff, crow_in;
   logic [6:0] x0_ff, x0_in;
   logic [5:0] y0_ff, y0_in;
   logic [4:0] col_ff, col_in;
   logic [4:0] row_ff, row_in;
   logic       char_ff, char_in;
   logic       fg_ff, fg_in;
   logic       load_ff, load_in;
   logic [mfb_pkg::GADDR_W-1:0]  red_ff, red_in;
   logic [mfb_pkg::GLYPH_AW-1:0] gaddr_ff, gaddr_in;
   logic [15:0] fword_ff, fword_in;
   logic [mfb_pkg::FRAME_AW-1:0] baddr_ff, baddr_in;
   logic [mfb_pkg::FRAME_AW-1:0] fill_addr_ff, fill_addr_in;
   logic       fill_val_ff, fill_val_in;
   logic       status_ff, status_in;
   logic [7:0] rd_ff, rd_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [mfb_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // memory ports
   logic                          frame_we, frame_re;
   logic [mfb_pkg::FRAME_AW-1:0]  frame_waddr, frame_raddr;
   logic [7:0]                    frame_wdata, frame_q;
   logic                          glyph_we, glyph_re;
   logic [15:0]                   glyph_q;

   mfb_pkg::pix_req_type          pix;
   logic [mfb_pkg::FRAME_AW-1:0]  pix_idx;
   logic [7:0]                    pix_byte;
   logic                          glyph_on;
   logic                          char_reject;
   logic                          pix_inside;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff  <= mfb_pkg::FONT_WIDTH_RST;
         fh_ff  <= mfb_pkg::FONT_HEIGHT_RST;
         inv_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            mfb_pkg::CSR_FONT_WIDTH:  fw_ff  <= csr_wdata;
            mfb_pkg::CSR_FONT_HEIGHT: fh_ff  <= csr_wdata;
            mfb_pkg::CSR_INVERT:      inv_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // pixel under work: glyph bit j is row-word bit 15 - j, none for j of 16 or more
   assign glyph_on  = !col_ff[4] && glyph_q[~col_ff[3:0]];
   assign pix.x     = {1'b0, x0_ff} + {3'b000, col_ff};
   assign pix.y     = {1'b0, y0_ff} + {2'b00, row_ff};
   assign pix.white = ((!char_ff || glyph_on) ? fg_ff : !fg_ff) ^ inv_ff;

   mfb_pixel_unit u_pixel (
      .pix      (pix),
      .old_byte (frame_q),
      .byte_idx (pix_idx),
      .new_byte (pix_byte)
   );

   assign char_reject = (char_code < 7'(mfb_pkg::FIRST_CODE))
                     || (32'(ccol_ff) + 32'(fw_ff) >= mfb_pkg::DISPLAY_WIDTH)
                     || (32'(crow_ff) + 32'(fh_ff) >= mfb_pkg::DISPLAY_HEIGHT);
   assign pix_inside  = (32'(pos_x) < mfb_pkg::DISPLAY_WIDTH)
                     && (32'(pos_y) < mfb_pkg::DISPLAY_HEIGHT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfb_pkg::ST_CLEAR;
         ccol_ff      <= '0;
         crow_ff      <= '0;
         fill_addr_ff <= '0;
         fill_val_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ccol_ff      <= ccol_in;
         crow_ff      <= crow_in;
         fill_addr_ff <= fill_addr_in;
         fill_val_ff  <= fill_val_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x0_ff       <= x0_in;
      y0_ff       <= y0_in;
      col_ff      <= col_in;
      row_ff      <= row_in;
      char_ff     <= char_in;
      fg_ff       <= fg_in;
      load_ff     <= load_in;
      red_ff      <= red_in;
      gaddr_ff    <= gaddr_in;
      fword_ff    <= fword_in;
      baddr_ff    <= baddr_in;
      status_ff   <= status_in;
      rd_ff       <= rd_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      state_in     = state_ff;
      ccol_in      = ccol_ff;
      crow_in      = crow_ff;
      x0_in        = x0_ff;
      y0_in        = y0_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      char_in      = char_ff;
      fg_in        = fg_ff;
      load_in      = load_ff;
      red_in       = red_ff;
      gaddr_in     = gaddr_ff;
      fword_in     = fword_ff;
      baddr_in     = baddr_ff;
      fill_addr_in = fill_addr_ff;
      fill_val_in  = fill_val_ff;
      status_in    = status_ff;
      rd_in        = rd_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      req_tready  = 1'b0;
      frame_we    = 1'b0;
      frame_re    = 1'b0;
      frame_waddr = pix_idx;
      frame_raddr = pix_idx;
      frame_wdata = pix_byte;
      glyph_we    = 1'b0;
      glyph_re    = 1'b0;

      unique case (state_ff)
         mfb_pkg::ST_CLEAR, mfb_pkg::ST_FILL: begin
            frame_we    = 1'b1;
            frame_waddr = fill_addr_ff;
            frame_wdata = {8{fill_val_ff}};
            if (fill_addr_ff == mfb_pkg::FRAME_AW'(mfb_pkg::FRAME_BYTES - 1)) begin
               fill_addr_in = '0;
               state_in     = (state_ff == mfb_pkg::ST_CLEAR) ? mfb_pkg::ST_IDLE
                                                              : mfb_pkg::ST_DONE;
            end else begin
               fill_addr_in = fill_addr_ff + 1'b1;
            end
         end

         mfb_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               status_in = 1'b0;
               rd_in     = 8'h00;
               col_in    = '0;
               row_in    = '0;
               fg_in     = color;
               state_in  = mfb_pkg::ST_DONE;
               unique case (mfb_pkg::action_type'(req_tuser))
                  mfb_pkg::ACT_FILL: begin
                     fill_val_in  = color;
                     fill_addr_in = '0;
                     state_in     = mfb_pkg::ST_FILL;
                  end
                  mfb_pkg::ACT_PIXEL: begin
                     x0_in   = pos_x;
                     y0_in   = pos_y;
                     char_in = 1'b0;
                     if (pix_inside) begin
                        state_in = mfb_pkg::ST_PIX_RD;
                     end
                  end
                  mfb_pkg::ACT_CURSOR: begin
                     ccol_in = pos_x;
                     crow_in = pos_y;
                  end
                  mfb_pkg::ACT_CHAR: begin
                     if (char_reject) begin
                        status_in = 1'b1;
                     end else begin
                        x0_in    = ccol_ff;
                        y0_in    = crow_ff;
                        char_in  = 1'b1;
                        load_in  = 1'b0;
                        red_in   = mfb_pkg::GADDR_W'(
                                      32'(char_code - 7'(mfb_pkg::FIRST_CODE))
                                      * 32'(fh_ff));
                        ccol_in  = 7'(ccol_ff + 7'(fw_ff));
                        state_in = mfb_pkg::ST_REDUCE;
                     end
                  end
                  mfb_pkg::ACT_FONT: begin
                     red_in   = mfb_pkg::GADDR_W'(font_address);
                     fword_in = font_word;
                     load_in  = 1'b1;
                     state_in = mfb_pkg::ST_REDUCE;
                  end
                  mfb_pkg::ACT_READ: begin
                     baddr_in = mfb_pkg::FRAME_AW'(byte_address);
                     if (32'(byte_address) < mfb_pkg::FRAME_BYTES) begin
                        state_in = mfb_pkg::ST_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // glyph address modulo the store size, one subtract per cycle
         mfb_pkg::ST_REDUCE: begin
            if (32'(red_ff) >= mfb_pkg::GLYPH_WORDS) begin
               red_in = red_ff - mfb_pkg::GADDR_W'(mfb_pkg::GLYPH_WORDS);
            end else if (load_ff) begin
               glyph_we = 1'b1;
               state_in = mfb_pkg::ST_DONE;
            end else if (fw_ff == 5'd0 || fh_ff == 5'd0) begin
               state_in = mfb_pkg::ST_DONE;
            end else begin
               gaddr_in = mfb_pkg::GLYPH_AW'(red_ff);
               state_in = mfb_pkg::ST_GROW;
            end
         end

         mfb_pkg::ST_GROW: begin
            glyph_re = 1'b1;
            col_in   = '0;
            state_in = mfb_pkg::ST_PIX_RD;
         end

         mfb_pkg::ST_PIX_RD: begin
            frame_re = 1'b1;
            state_in = mfb_pkg::ST_PIX_WR;
         end

         mfb_pkg::ST_PIX_WR: begin
            frame_we = 1'b1;
            if (!char_ff) begin
               state_in = mfb_pkg::ST_DONE;
            end else if (col_ff != fw_ff - 5'd1) begin
               col_in   = col_ff + 5'd1;
               state_in = mfb_pkg::ST_PIX_RD;
            end else if (row_ff == fh_ff - 5'd1) begin
               state_in = mfb_pkg::ST_DONE;
            end else begin
               row_in   = row_ff + 5'd1;
               gaddr_in = (gaddr_ff == mfb_pkg::GLYPH_AW'(mfb_pkg::GLYPH_WORDS - 1))
                          ? '0 : gaddr_ff + 1'b1;
               state_in = mfb_pkg::ST_GROW;
            end
         end

         mfb_pkg::ST_READ: begin
            frame_re    = 1'b1;
            frame_raddr = baddr_ff;
            state_in    = mfb_pkg::ST_RDCAP;
         end

         mfb_pkg::ST_RDCAP: begin
            rd_in    = frame_q;
            state_in = mfb_pkg::ST_DONE;
         end

         mfb_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {7'b0000000, status_ff, rd_ff};
               state_in     = mfb_pkg::ST_IDLE;
            end
         end

         default: state_in = mfb_pkg::ST_IDLE;
      endcase
   end

   mfb_ram #(
      .WIDTH (8),
      .DEPTH (mfb_pkg::FRAME_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (frame_we),
      .wr_addr (frame_waddr),
      .wr_data (frame_wdata),
      .rd_en   (frame_re),
      .rd_addr (frame_raddr),
      .rd_data (frame_q)
   );

   mfb_ram #(
      .WIDTH (16),
      .DEPTH (mfb_pkg::GLYPH_WORDS)
   ) u_glyph_ram (
      .clock   (clock),
      .wr_en   (glyph_we),
      .wr_addr (mfb_pkg::GLYPH_AW'(red_ff)),
      .wr_data (fword_ff),
      .rd_en   (glyph_re),
      .rd_addr (gaddr_ff),
      .rd_data (glyph_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // the clearing pass holds off requests right after reset
   `MFB_ASSERT_ALWAYS(a_clear_after_reset, clock, $past(reset) |-> !req_tready)
   // every frame write lands inside the buffer
   `MFB_ASSERT(a_frame_write_in_range, clock, reset, frame_we |-> 32'(frame_waddr) < mfb_pkg::FRAME_BYTES)
   // glyph column never runs past the font width
   `MFB_ASSERT(a_col_in_glyph, clock, reset, (state_ff == mfb_pkg::ST_PIX_WR && char_ff) |-> col_ff < fw_ff)

endmodule
